// ----- rtl/pairwise_level_set_classify_defines.svh -----
// assertion macros for the pairwise level-set classifier
`ifndef PAIRWISE_LEVEL_SET_CLASSIFY_DEFINES_SVH
`define PAIRWISE_LEVEL_SET_CLASSIFY_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PLSC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pairwise_level_set_classify: check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define PLSC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pairwise_level_set_classify: check failed");

`endif

// ----- rtl/plsc_pkg.sv -----
// types and constants of the pairwise level-set classifier
`default_nettype none

package plsc_pkg;

    localparam int unsigned PHI_W   = 32;
    localparam int unsigned CFG_W   = 31;
    localparam int unsigned COLOR_W = 4;
    localparam int unsigned MASK_W  = 8;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned WIDE_W  = 35;

    localparam logic signed [PHI_W-1:0] MAX_CODE = 32'sh7FFF_FFFF;
    localparam logic [COLOR_W-1:0]      NO_COLOR = 4'hF;

    localparam logic [CFG_W-1:0] VALID_WIDTH_RESET  = 31'd196608;
    localparam logic [CFG_W-1:0] EXTENT_RESET       = 31'd589824;
    localparam logic [CFG_W-1:0] TRUST_BUFFER_RESET = 31'd65536;

    localparam logic [1:0] REG_VALID_WIDTH  = 2'd0;
    localparam logic [1:0] REG_EXTENT       = 2'd1;
    localparam logic [1:0] REG_TRUST_BUFFER = 2'd2;

    typedef enum logic [1:0] {
        OUTCOME_TRUSTED     = 2'd0,
        OUTCOME_AMBIGUOUS   = 2'd1,
        OUTCOME_OUT_OF_BAND = 2'd2
    } outcome_t;

endpackage

`default_nettype wire

// ----- rtl/pairwise_level_set_classify.sv -----
// a node's last item passes the input stage, then its result goes to the node snapshot and the result register
// throughput: one item per cycle, stalled only when both internal stages and the
// result register hold node results that the output side has not taken
// reset: rst_n (async, active low) empties the pipeline, clears the node state
// and loads the register defaults 3.0, 9.0 and 1.0
`default_nettype none

`include "pairwise_level_set_classify_defines.svh"

module pairwise_level_set_classify #(
    parameter int unsigned NUM_COLORS = 8
) (
    input  wire                                    clk,
    input  wire                                    rst_n,

    input  wire                                    psel,
    input  wire                                    penable,
    input  wire                                    pwrite,
    input  wire  [plsc_pkg::ADDR_W-1:0]            paddr,
    input  wire  [plsc_pkg::DATA_W-1:0]            pwdata,
    output logic [plsc_pkg::DATA_W-1:0]            prdata,
    output logic                                   pready,

    input  wire                                    in_valid,
    output logic                                   in_ready,
    input  wire  signed [plsc_pkg::PHI_W-1:0]      phi_value,
    input  wire                                    last_color,

    output logic                                   out_valid,
    input  wire                                    out_ready,
    output logic [plsc_pkg::MASK_W-1:0]            valid_mask,
    output logic signed [plsc_pkg::COLOR_W-1:0]    lower_color,
    output logic signed [plsc_pkg::COLOR_W-1:0]    upper_color,
    output logic signed [plsc_pkg::PHI_W-1:0]      pair_phi,
    output logic [1:0]                             outcome
);

    localparam int unsigned CW = $clog2(NUM_COLORS + 1);

    // configuration
    logic [plsc_pkg::CFG_W-1:0] vw_reg;
    logic [plsc_pkg::CFG_W-1:0] ext_reg;
    logic [plsc_pkg::CFG_W-1:0] tb_reg;
    logic                       cfg_wr;

    // input stage
    logic                              s1_valid_reg;
    logic signed [plsc_pkg::PHI_W-1:0] s1_phi_reg;
    logic                              s1_last_reg;

    // running node state
    logic signed [plsc_pkg::PHI_W-1:0] least_reg,  least_next;
    logic signed [plsc_pkg::PHI_W-1:0] second_reg, second_next;
    logic signed [plsc_pkg::PHI_W-1:0] third_reg,  third_next;
    logic [plsc_pkg::COLOR_W-1:0]      lcol_reg,   lcol_next;
    logic [plsc_pkg::COLOR_W-1:0]      scol_reg,   scol_next;
    logic [plsc_pkg::MASK_W-1:0]       mask_reg,   mask_next;
    logic [CW-1:0]                     cnt_reg;

    // node snapshot
    logic                              s2_valid_reg;
    logic signed [plsc_pkg::PHI_W-1:0] s2_least_reg;
    logic signed [plsc_pkg::PHI_W-1:0] s2_second_reg;
    logic signed [plsc_pkg::PHI_W-1:0] s2_third_reg;
    logic [plsc_pkg::COLOR_W-1:0]      s2_lcol_reg;
    logic [plsc_pkg::COLOR_W-1:0]      s2_scol_reg;
    logic [plsc_pkg::MASK_W-1:0]       s2_mask_reg;

    // result register
    logic                              out_valid_reg;
    logic [plsc_pkg::MASK_W-1:0]       out_mask_reg,    out_mask_next;
    logic [plsc_pkg::COLOR_W-1:0]      out_lower_reg,   out_lower_next;
    logic [plsc_pkg::COLOR_W-1:0]      out_upper_reg,   out_upper_next;
    logic signed [plsc_pkg::PHI_W-1:0] out_phi_reg,     out_phi_next;
    plsc_pkg::outcome_t                out_outcome_reg, out_outcome_next;

    // handshake
    logic s1_adv;
    logic s2_adv;
    logic s2_ready;
    logic take;

    logic [4:0]                   cnt_ext;
    logic [plsc_pkg::COLOR_W-1:0] cur_color;
    logic                         in_band;

    logic signed [plsc_pkg::WIDE_W-1:0] v0;
    logic signed [plsc_pkg::WIDE_W-1:0] v1;
    logic signed [plsc_pkg::WIDE_W-1:0] v2;
    logic signed [plsc_pkg::WIDE_W-1:0] sh1;
    logic signed [plsc_pkg::WIDE_W-1:0] sh2;
    logic signed [plsc_pkg::WIDE_W-1:0] vw2;
    logic signed [plsc_pkg::WIDE_W-1:0] ext2;
    logic signed [plsc_pkg::WIDE_W-1:0] tb2;
    logic                               missing;
    logic [plsc_pkg::PHI_W-1:0]         half;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[3:2])
            plsc_pkg::REG_VALID_WIDTH:  prdata = {1'b0, vw_reg};
            plsc_pkg::REG_EXTENT:       prdata = {1'b0, ext_reg};
            plsc_pkg::REG_TRUST_BUFFER: prdata = {1'b0, tb_reg};
            default:                    prdata = '0;
        endcase
    end

    assign s2_adv   = !out_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s2_adv;
    assign s1_adv   = s1_valid_reg && (!s1_last_reg || s2_ready);
    assign in_ready = !s1_valid_reg || s1_adv;

    // per-color update of the running minima and mask
    assign take      = cnt_reg < CW'(NUM_COLORS);
    assign cnt_ext   = 5'(cnt_reg);
    assign cur_color = cnt_ext[plsc_pkg::COLOR_W-1:0];
    assign in_band   = $signed({s1_phi_reg[plsc_pkg::PHI_W-1], s1_phi_reg})
                       <= $signed({2'b00, vw_reg});

    always_comb
    begin
        least_next  = least_reg;
        second_next = second_reg;
        third_next  = third_reg;
        lcol_next   = lcol_reg;
        scol_next   = scol_reg;
        mask_next   = mask_reg;
        if (take)
        begin
            if (s1_phi_reg < least_reg)
            begin
                third_next  = second_reg;
                second_next = least_reg;
                scol_next   = lcol_reg;
                least_next  = s1_phi_reg;
                lcol_next   = cur_color;
            end
            else if (s1_phi_reg < second_reg)
            begin
                third_next  = second_reg;
                second_next = s1_phi_reg;
                scol_next   = cur_color;
            end
            else if (s1_phi_reg < third_reg)
            begin
                third_next = s1_phi_reg;
            end
            if (in_band && (cnt_ext < 5'd8))
            begin
                mask_next = mask_reg | (plsc_pkg::MASK_W'(1) << cnt_ext[2:0]);
            end
        end
    end

    // classification at twice the scale
    assign v0   = plsc_pkg::WIDE_W'(s2_least_reg);
    assign v1   = plsc_pkg::WIDE_W'(s2_second_reg);
    assign v2   = plsc_pkg::WIDE_W'(s2_third_reg);
    assign sh1  = v1 - v0;
    assign sh2  = (v2 <<< 1) - v0 - v1;
    assign vw2  = $signed({3'b000, vw_reg, 1'b0});
    assign ext2 = $signed({3'b000, ext_reg, 1'b0});
    assign tb2  = $signed({3'b000, tb_reg, 1'b0});
    assign half = sh1[plsc_pkg::PHI_W:1];
    assign missing = (s2_second_reg == plsc_pkg::MAX_CODE)
                     || (s2_third_reg == plsc_pkg::MAX_CODE);

    always_comb
    begin
        out_mask_next    = s2_mask_reg;
        out_lower_next   = plsc_pkg::NO_COLOR;
        out_upper_next   = plsc_pkg::NO_COLOR;
        out_phi_next     = plsc_pkg::MAX_CODE;
        out_outcome_next = plsc_pkg::OUTCOME_TRUSTED;
        if (missing || (sh1 > vw2) || (sh2 > ext2))
        begin
            out_mask_next    = '0;
            out_outcome_next = plsc_pkg::OUTCOME_OUT_OF_BAND;
        end
        else if (sh1 > (sh2 - tb2))
        begin
            out_outcome_next = plsc_pkg::OUTCOME_AMBIGUOUS;
        end
        else if (s2_lcol_reg < s2_scol_reg)
        begin
            out_lower_next = s2_lcol_reg;
            out_upper_next = s2_scol_reg;
            out_phi_next   = -$signed(half);
        end
        else
        begin
            out_lower_next = s2_scol_reg;
            out_upper_next = s2_lcol_reg;
            out_phi_next   = $signed(half);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vw_reg        <= plsc_pkg::VALID_WIDTH_RESET;
            ext_reg       <= plsc_pkg::EXTENT_RESET;
            tb_reg        <= plsc_pkg::TRUST_BUFFER_RESET;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            least_reg     <= plsc_pkg::MAX_CODE;
            second_reg    <= plsc_pkg::MAX_CODE;
            third_reg     <= plsc_pkg::MAX_CODE;
            lcol_reg      <= plsc_pkg::NO_COLOR;
            scol_reg      <= plsc_pkg::NO_COLOR;
            mask_reg      <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (paddr[3:2])
                    plsc_pkg::REG_VALID_WIDTH:  vw_reg  <= pwdata[plsc_pkg::CFG_W-1:0];
                    plsc_pkg::REG_EXTENT:       ext_reg <= pwdata[plsc_pkg::CFG_W-1:0];
                    plsc_pkg::REG_TRUST_BUFFER: tb_reg  <= pwdata[plsc_pkg::CFG_W-1:0];
                    default:                    ;
                endcase
            end

            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end

            if (s1_adv && s1_last_reg)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (s2_adv)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (s2_adv)
            begin
                out_valid_reg <= s2_valid_reg;
            end

            if (s1_adv)
            begin
                if (s1_last_reg)
                begin
                    least_reg  <= plsc_pkg::MAX_CODE;
                    second_reg <= plsc_pkg::MAX_CODE;
                    third_reg  <= plsc_pkg::MAX_CODE;
                    lcol_reg   <= plsc_pkg::NO_COLOR;
                    scol_reg   <= plsc_pkg::NO_COLOR;
                    mask_reg   <= '0;
                    cnt_reg    <= '0;
                end
                else
                begin
                    least_reg  <= least_next;
                    second_reg <= second_next;
                    third_reg  <= third_next;
                    lcol_reg   <= lcol_next;
                    scol_reg   <= scol_next;
                    mask_reg   <= mask_next;
                    if (take)
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_phi_reg  <= phi_value;
            s1_last_reg <= last_color;
        end
        if (s1_adv && s1_last_reg)
        begin
            s2_least_reg  <= least_next;
            s2_second_reg <= second_next;
            s2_third_reg  <= third_next;
            s2_lcol_reg   <= lcol_next;
            s2_scol_reg   <= scol_next;
            s2_mask_reg   <= mask_next;
        end
        if (s2_adv && s2_valid_reg)
        begin
            out_mask_reg    <= out_mask_next;
            out_lower_reg   <= out_lower_next;
            out_upper_reg   <= out_upper_next;
            out_phi_reg     <= out_phi_next;
            out_outcome_reg <= out_outcome_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign valid_mask  = out_mask_reg;
    assign lower_color = $signed(out_lower_reg);
    assign upper_color = $signed(out_upper_reg);
    assign pair_phi    = out_phi_reg;
    assign outcome     = out_outcome_reg;

    // out of band clears mask and pair
    `PLSC_ASSERT_IMP(a_band_clear,
        out_valid_reg && (out_outcome_reg == plsc_pkg::OUTCOME_OUT_OF_BAND),
        (out_mask_reg == '0) && (out_phi_reg == plsc_pkg::MAX_CODE))

    // a trusted pair is strictly ordered
    `PLSC_ASSERT_IMP(a_pair_order,
        out_valid_reg && (out_outcome_reg == plsc_pkg::OUTCOME_TRUSTED),
        out_lower_reg < out_upper_reg)

    // the node state restarts after a last transfer
    `PLSC_ASSERT_NXT(a_node_restart,
        s1_adv && s1_last_reg,
        (cnt_reg == '0) && (least_reg == plsc_pkg::MAX_CODE))

endmodule

`default_nettype wire
